### rtl/core/egil_pkg.sv
// Shared types and constants for the energy grid interval lookup.
// Used by the divider, the top level and the checker; depends on nothing.
package egil_pkg;

  // Grid storage and weight scaling
  localparam int GRID_DEPTH  = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int GRID_AW     = $clog2(GRID_DEPTH);

  // Fixed field widths of the channels
  localparam int ENERGY_W = 48;
  localparam int INDEX_W  = 10;
  localparam int WEIGHT_W = 17;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;
  localparam int DIV_CNT_W = $clog2(WEIGHT_BITS + 1);

  typedef logic [ENERGY_W-1:0]  energy_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [WEIGHT_W-1:0]  weight_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [GRID_AW-1:0]   gaddr_t;
  typedef logic [GRID_AW:0]     gcnt_t;
  typedef logic [WEIGHT_BITS:0] frac_t;
  typedef logic [DIV_CNT_W-1:0] divcnt_t;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Range status codes
  localparam status_t ST_INSIDE   = 2'd0;
  localparam status_t ST_BELOW    = 2'd1;
  localparam status_t ST_ABOVE    = 2'd2;
  localparam status_t ST_LOAD_ACK = 2'd3;

  // Unity factor
  localparam frac_t   FRAC_ONE   = frac_t'(1) << WEIGHT_BITS;
  localparam weight_t WEIGHT_ONE = weight_t'(FRAC_ONE);

  localparam cfg_t CFG_RESET = cfg_t'(2);

  typedef struct packed {
    logic    command;
    index_t  address;
    energy_t energy;
    index_t  hint_index;
  } in_item_t;

  typedef struct packed {
    index_t  interval_index;
    weight_t weight;
    status_t range_status;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic    go;
    energy_t energy;
    energy_t lo;
    energy_t hi;
  } div_req_t;

  typedef struct packed {
    logic  done;
    frac_t weight;
  } div_rsp_t;

endpackage

### rtl/core/egil_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; a read in the same cycle as a write returns the old word.
module egil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/egil_div.sv
// Interpolation factor unit: restoring divider, one quotient bit a cycle.
// Depends on egil_pkg for the request and response structs.
module egil_div (
  input  logic                clk,
  input  logic                rst_n,
  input  egil_pkg::div_req_t  req,
  output egil_pkg::div_rsp_t  rsp
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  egil_pkg::divcnt_t         cnt_r, cnt_nxt;
  egil_pkg::energy_t         rem_r, rem_nxt;
  egil_pkg::energy_t         den_r, den_nxt;
  egil_pkg::frac_t           w_r, w_nxt;
  logic [egil_pkg::ENERGY_W:0] rem2;
  logic [egil_pkg::ENERGY_W:0] den2;
  logic                      geq;

  // Shifted remainder against the divisor
  assign rem2 = {rem_r, 1'b0};
  assign den2 = {1'b0, den_r};
  assign geq  = rem2 >= den2;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    w_nxt    = w_r;
    if (req.go) begin
      // Clip at the interval ends, otherwise load the fraction
      if (req.hi <= req.lo || req.energy <= req.lo) begin
        w_nxt    = '0;
        done_nxt = 1'b1;
      end else if (req.energy >= req.hi) begin
        w_nxt    = egil_pkg::FRAC_ONE;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = req.energy - req.lo;
        den_nxt  = req.hi - req.lo;
        w_nxt    = '0;
        cnt_nxt  = egil_pkg::divcnt_t'(egil_pkg::WEIGHT_BITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // Produce one quotient bit
      rem_nxt = geq ? egil_pkg::energy_t'(rem2 - den2) : egil_pkg::energy_t'(rem2);
      w_nxt   = {w_r[egil_pkg::WEIGHT_BITS-1:0], geq};
      cnt_nxt = cnt_r - egil_pkg::divcnt_t'(1);
      if (cnt_r == egil_pkg::divcnt_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    w_r   <= w_nxt;
  end

  assign rsp = '{done: done_r, weight: w_r};

endmodule

### rtl/core/energy_grid_interval_lookup.sv
// Energy grid interval lookup: top level with the query sequencer.
// Depends on egil_pkg, egil_ram (grid store) and egil_div (factor unit).
//
// Usage
//   Items enter on start while busy is low. A load item writes one grid point
//   and is acknowledged on the next cycle; busy stays low, so loads stream at
//   one beat per cycle. A query raises busy until its result is ready.
//   Every item gives exactly one result beat: out_valid is high for one cycle
//   with out_item. The receiver cannot stall; results are never held.
//   A query checks the first grid point (S_CK0), then the last (S_CKL),
//   then the hinted interval (S_HLO, S_HHI); when the hint misses or is
//   out of range, a binary search (S_SRCH) and a read of the interval ends
//   (S_ILO, S_IHI) follow, and the divider (S_DIV) gives the factor. The
//   binary search takes one grid RAM read a cycle and the restoring divider
//   one quotient bit a cycle.
//   The cfg channel writes points_in_use; it is always ready and must only be
//   written while the block is idle.
//   Reset clears the sequencer and sets points_in_use to 2; the grid RAM is
//   not cleared, and a point must be loaded before it is searched.
module energy_grid_interval_lookup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  egil_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output egil_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  egil_pkg::cfg_t       cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CK0  = 4'd1;
  localparam logic [3:0] S_CKL  = 4'd2;
  localparam logic [3:0] S_HLO  = 4'd3;
  localparam logic [3:0] S_HHI  = 4'd4;
  localparam logic [3:0] S_SRCH = 4'd5;
  localparam logic [3:0] S_ILO  = 4'd6;
  localparam logic [3:0] S_IHI  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;

  logic [3:0]          state_r, state_nxt;
  egil_pkg::cfg_t      cfg_r;
  egil_pkg::energy_t   e_r, e_nxt;
  egil_pkg::index_t    hint_r, hint_nxt;
  egil_pkg::energy_t   lo_r, lo_nxt;
  egil_pkg::gaddr_t    idx_r, idx_nxt;
  egil_pkg::gcnt_t     first_r, first_nxt;
  egil_pkg::gcnt_t     count_r, count_nxt;
  egil_pkg::gcnt_t     mid_r, mid_nxt;
  logic                out_valid_r, out_valid_nxt;
  egil_pkg::out_item_t out_item_r, out_item_nxt;

  logic                ram_we;
  egil_pkg::gaddr_t    ram_addr;
  egil_pkg::energy_t   ram_wdata;
  egil_pkg::energy_t   ram_rdata;
  egil_pkg::div_req_t  div_req;
  egil_pkg::div_rsp_t  div_rsp;

  logic                accept;
  egil_pkg::gcnt_t     n_eff, nm1, nm2;
  egil_pkg::gcnt_t     half, first_s, count_s, ub_m1, idx_c;
  logic                srch_le;

  assign accept    = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  // Clamp the point count to between 2 and the storage depth
  always_comb begin
    if (cfg_r inside {[0:1]}) begin
      n_eff = egil_pkg::gcnt_t'(2);
    end else if (cfg_r > egil_pkg::GRID_DEPTH) begin
      n_eff = egil_pkg::gcnt_t'(egil_pkg::GRID_DEPTH);
    end else begin
      n_eff = egil_pkg::gcnt_t'(cfg_r);
    end
  end

  assign nm1 = n_eff - egil_pkg::gcnt_t'(1);
  assign nm2 = n_eff - egil_pkg::gcnt_t'(2);

  // One upper-bound search step on the word read at mid_r
  assign half    = count_r >> 1;
  assign srch_le = ram_rdata <= e_r;
  assign first_s = srch_le ? mid_r + egil_pkg::gcnt_t'(1) : first_r;
  assign count_s = srch_le ? count_r - half - egil_pkg::gcnt_t'(1) : half;
  assign ub_m1   = (first_s != '0) ? first_s - egil_pkg::gcnt_t'(1) : '0;
  assign idx_c   = (ub_m1 > nm2) ? nm2 : ub_m1;

  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    hint_nxt      = hint_r;
    lo_nxt        = lo_r;
    idx_nxt       = idx_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = in_item.energy;
    div_req       = '{go: 1'b0, energy: e_r, lo: lo_r, hi: ram_rdata};
    case (state_r)
      S_IDLE: begin
        // First point is read while idle, ready for a query
        if (accept) begin
          if (in_item.command == egil_pkg::CMD_LOAD) begin
            ram_we        = in_item.address < egil_pkg::GRID_DEPTH;
            ram_addr      = egil_pkg::gaddr_t'(in_item.address);
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{interval_index: '0, weight: '0,
                              range_status: egil_pkg::ST_LOAD_ACK};
          end else begin
            e_nxt     = in_item.energy;
            hint_nxt  = in_item.hint_index;
            state_nxt = S_CK0;
          end
        end
      end
      S_CK0: begin
        ram_addr = nm1[egil_pkg::GRID_AW-1:0];
        if (e_r <= ram_rdata) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{interval_index: '0, weight: '0,
                            range_status: egil_pkg::ST_BELOW};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CKL;
        end
      end
      S_CKL: begin
        if (e_r >= ram_rdata) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{interval_index: egil_pkg::index_t'(nm2),
                            weight: egil_pkg::WEIGHT_ONE,
                            range_status: egil_pkg::ST_ABOVE};
          state_nxt     = S_IDLE;
        end else if (hint_r <= nm2) begin
          ram_addr  = egil_pkg::gaddr_t'(hint_r);
          state_nxt = S_HLO;
        end else begin
          first_nxt = '0;
          count_nxt = n_eff;
          mid_nxt   = n_eff >> 1;
          ram_addr  = mid_nxt[egil_pkg::GRID_AW-1:0];
          state_nxt = S_SRCH;
        end
      end
      S_HLO: begin
        lo_nxt    = ram_rdata;
        ram_addr  = egil_pkg::gaddr_t'(hint_r) + egil_pkg::gaddr_t'(1);
        state_nxt = S_HHI;
      end
      S_HHI: begin
        // Keep the hint if it holds the energy, else search
        if (e_r >= lo_r && e_r <= ram_rdata) begin
          idx_nxt    = egil_pkg::gaddr_t'(hint_r);
          div_req.go = 1'b1;
          state_nxt  = S_DIV;
        end else begin
          first_nxt = '0;
          count_nxt = n_eff;
          mid_nxt   = n_eff >> 1;
          ram_addr  = mid_nxt[egil_pkg::GRID_AW-1:0];
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        first_nxt = first_s;
        count_nxt = count_s;
        if (count_s != '0) begin
          mid_nxt  = first_s + (count_s >> 1);
          ram_addr = mid_nxt[egil_pkg::GRID_AW-1:0];
        end else begin
          idx_nxt   = idx_c[egil_pkg::GRID_AW-1:0];
          ram_addr  = idx_c[egil_pkg::GRID_AW-1:0];
          state_nxt = S_ILO;
        end
      end
      S_ILO: begin
        lo_nxt    = ram_rdata;
        ram_addr  = idx_r + egil_pkg::gaddr_t'(1);
        state_nxt = S_IHI;
      end
      S_IHI: begin
        div_req.go = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{interval_index: egil_pkg::index_t'(idx_r),
                            weight: egil_pkg::weight_t'(div_rsp.weight),
                            range_status: egil_pkg::ST_INSIDE};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= egil_pkg::CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
    e_r        <= e_nxt;
    hint_r     <= hint_nxt;
    lo_r       <= lo_nxt;
    idx_r      <= idx_nxt;
    first_r    <= first_nxt;
    count_r    <= count_nxt;
    mid_r      <= mid_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  egil_ram #(
    .WIDTH (egil_pkg::ENERGY_W),
    .DEPTH (egil_pkg::GRID_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  egil_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

### rtl/core/egil_chk.sv
// Port-level checker for the energy grid interval lookup.
// Depends on egil_pkg; bound to the top level at the end of this file.
module egil_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input egil_pkg::in_item_t  in_item,
  input logic                out_valid,
  input egil_pkg::out_item_t out_item
);

  // A load beat is acknowledged on the next cycle
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command == egil_pkg::CMD_LOAD) |=>
    (out_valid && out_item.range_status == egil_pkg::ST_LOAD_ACK))
    else $error("load beat not acknowledged");

  // A query beat holds off further items
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command == egil_pkg::CMD_QUERY) |=> busy)
    else $error("query accepted without busy");

  // A query result comes as busy drops
  a_query_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.range_status != egil_pkg::ST_LOAD_ACK) |->
    ($past(busy) && !busy))
    else $error("query result outside busy drop");

  // Below the grid gives the first interval with zero factor
  a_below: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.range_status == egil_pkg::ST_BELOW) |->
    (out_item.interval_index == '0 && out_item.weight == '0))
    else $error("below-grid result malformed");

  // Above the grid gives unity factor
  a_above: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.range_status == egil_pkg::ST_ABOVE) |->
    (out_item.weight == egil_pkg::WEIGHT_ONE))
    else $error("above-grid factor not unity");

endmodule

bind energy_grid_interval_lookup egil_chk u_egil_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
